/* hdl/rrl_pkg.sv */
// Shared types and constants for the ring resampler with linear interpolation.
// Holds the transaction payload structs, the opcode and the control phase encoding.
// No dependencies.
package rrl_pkg;

    // Opcode of one input transaction.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Fixed widths of the play position, its fraction and the pitch step.
    localparam int POS_W  = 48;
    localparam int FRAC_W = 32;
    localparam int STEP_W = 40;

    // Saturation value of the fill count and reset value of the pitch step.
    localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_UNITY = 40'h01_0000_0000;

    // Input transaction payload.
    typedef struct packed {
        logic               op;
        logic signed [15:0] sample_in;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               underrun;
        logic [10:0]        headroom;
        logic [POS_W-1:0]   position;
    } out_t;

    // Phase of the state update sequencer.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_LOAD   = 3'b010,
        PH_UPDATE = 3'b100
    } phase_t;

endpackage

/* hdl/ring_resampler_linear_interp.sv */
// Ring resampler top level: push/pull sequencer, interpolation pipeline, result queue.
// Depends on rrl_pkg and rrl_ring_mem.
//
// A transaction is taken only outside the load phase. The cycle after acceptance
// loads the play position (clamped to the oldest buffered sample) and reads samples
// i and i+1 from the two read ports of the ring, or writes a pushed sample; the
// update phase that follows writes the advanced position back. That read-modify-write
// of the position and fill count is what stalls input during the load phase. Each
// result passes a multiply stage and a final add stage after the update phase, and
// waits in a four-entry result queue. Input keeps flowing until four transactions are
// accepted but not yet delivered, and then stalls until a result is taken. RING_DEPTH
// must be a power of two. The pitch step may be written only while no transaction is
// in flight.
module ring_resampler_linear_interp #(
    parameter int RING_DEPTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [39:0]  cfg_wr_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  rrl_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output rrl_pkg::out_t out_data
);

    import rrl_pkg::*;

    localparam int AW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam logic [POS_W-1:0] DEPTH_W = POS_W'(RING_DEPTH);

    // Configuration and architectural state.
    logic [STEP_W-1:0] pitch_reg;
    logic [POS_W-1:0]  fill_reg,  fill_next;
    logic [POS_W-1:0]  low_reg,   low_next;
    logic [POS_W-1:0]  play_reg,  play_next;
    logic [FRAC_W-1:0] frac_reg,  frac_next;

    // Sequencer.
    phase_t phase_reg, phase_next;
    logic   in_fire;
    logic   item_op_reg;
    logic signed [15:0] item_sample_reg;

    // Clamped position held between the load and update phases.
    logic [POS_W-1:0]  idx_reg;
    logic [FRAC_W-1:0] idx_frac_reg;
    logic [POS_W-1:0]  idx_clamp;
    logic [FRAC_W-1:0] frac_clamp;
    logic              behind;

    // Ring memory interface.
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_addr_b;
    logic signed [15:0] mem_data_a;
    logic signed [15:0] mem_data_b;

    // Update phase signals.
    logic              under_now;
    logic [FRAC_W:0]   frac_sum;
    logic [POS_W-1:0]  play_adv;

    // Multiply stage registers.
    logic               x_valid_reg;
    logic               x_zero_reg;
    logic               x_under_reg;
    logic signed [15:0] x_a_reg;
    logic signed [16:0] x_d_reg;
    logic [15:0]        x_f16_reg;

    // Final stage registers.
    logic               y_valid_reg;
    logic               y_zero_reg;
    logic               y_under_reg;
    logic signed [15:0] y_a_reg;
    logic signed [33:0] y_prod_reg;
    logic [POS_W:0]     y_diff_reg;
    logic [POS_W-1:0]   y_pos_reg;
    logic signed [33:0] x_prod;

    // Result assembly.
    logic signed [33:0] prod_shift;
    logic [15:0]        interp;
    logic [POS_W-1:0]   room;
    out_t               result;

    // Result queue and occupancy.
    out_t           queue_reg [QDEPTH];
    logic [QAW-1:0] q_wr_ptr_reg;
    logic [QAW-1:0] q_rd_ptr_reg;
    logic [QAW:0]   q_count_reg;
    logic [QAW:0]   inflight_reg;
    logic           out_fire;

    // Handshakes.
    assign in_ready = (phase_reg != PH_LOAD) && (inflight_reg < (QAW+1)'(QDEPTH));
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Pitch step register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= STEP_UNITY;
        end
        else if (cfg_wr_en)
        begin
            pitch_reg <= cfg_wr_data;
        end
    end

    // Phase sequencing: accept, load, update, and a new accept during update.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:   phase_next = in_fire ? PH_LOAD : PH_IDLE;
            PH_LOAD:   phase_next = PH_UPDATE;
            PH_UPDATE: phase_next = in_fire ? PH_LOAD : PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    // Clamp the play position to the oldest buffered sample.
    assign behind     = play_reg < low_reg;
    assign idx_clamp  = behind ? low_reg : play_reg;
    assign frac_clamp = behind ? '0 : frac_reg;

    // Ring access during the load phase.
    assign mem_wr_en  = (phase_reg == PH_LOAD) && (item_op_reg == OP_PUSH)
                        && (fill_reg != POS_MAX);
    assign mem_rd_en  = (phase_reg == PH_LOAD) && (item_op_reg == OP_PULL);
    assign mem_addr_b = idx_clamp[AW-1:0] + AW'(1);

    rrl_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (fill_reg[AW-1:0]),
        .wr_data   (item_sample_reg),
        .rd_en     (mem_rd_en),
        .rd_addr_a (idx_clamp[AW-1:0]),
        .rd_addr_b (mem_addr_b),
        .rd_data_a (mem_data_a),
        .rd_data_b (mem_data_b)
    );

    // Underrun test and position advance during the update phase.
    assign under_now = ({1'b0, idx_reg} + (POS_W+1)'(1)) >= {1'b0, fill_reg};
    assign frac_sum  = {1'b0, idx_frac_reg} + {1'b0, pitch_reg[FRAC_W-1:0]};
    assign play_adv  = idx_reg + POS_W'(pitch_reg[STEP_W-1:FRAC_W]) + POS_W'(frac_sum[FRAC_W]);

    // Next values of the fill count, window start and play position.
    always_comb
    begin
        fill_next = fill_reg;
        low_next  = low_reg;
        play_next = play_reg;
        frac_next = frac_reg;
        if (mem_wr_en)
        begin
            fill_next = fill_reg + POS_W'(1);
            if (fill_reg >= DEPTH_W)
            begin
                low_next = low_reg + POS_W'(1);
            end
        end
        if ((phase_reg == PH_UPDATE) && (item_op_reg == OP_PULL))
        begin
            if (under_now)
            begin
                play_next = idx_reg;
                frac_next = idx_frac_reg;
            end
            else
            begin
                play_next = play_adv;
                frac_next = frac_sum[FRAC_W-1:0];
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            low_reg   <= '0;
            play_reg  <= '0;
            frac_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            low_reg   <= low_next;
            play_reg  <= play_next;
            frac_reg  <= frac_next;
        end
    end

    // Captured transaction and clamped position.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_op_reg     <= in_data.op;
            item_sample_reg <= in_data.sample_in;
        end
        if (phase_reg == PH_LOAD)
        begin
            idx_reg      <= idx_clamp;
            idx_frac_reg <= frac_clamp;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
        end
        else
        begin
            x_valid_reg <= (phase_reg == PH_UPDATE);
            y_valid_reg <= x_valid_reg;
        end
    end

    // Multiply stage inputs: difference of the two samples and the fraction.
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_UPDATE)
        begin
            x_zero_reg  <= (item_op_reg == OP_PUSH) || under_now;
            x_under_reg <= (item_op_reg == OP_PULL) && under_now;
            x_a_reg     <= mem_data_a;
            x_d_reg     <= 17'(mem_data_b) - 17'(mem_data_a);
            x_f16_reg   <= idx_frac_reg[FRAC_W-1:FRAC_W-16];
        end
    end

    // Product and the distance from play position to fill count.
    assign x_prod = 34'(x_d_reg) * $signed({18'b0, x_f16_reg});

    always_ff @(posedge clk)
    begin
        if (x_valid_reg)
        begin
            y_zero_reg  <= x_zero_reg;
            y_under_reg <= x_under_reg;
            y_a_reg     <= x_a_reg;
            y_prod_reg  <= x_prod;
            y_diff_reg  <= {1'b0, fill_reg} - {1'b0, play_reg};
            y_pos_reg   <= play_reg;
        end
    end

    // Final add with floor shift, and headroom.
    assign prod_shift = y_prod_reg >>> 16;
    assign interp     = y_a_reg + prod_shift[15:0];
    assign room       = DEPTH_W - y_diff_reg[POS_W-1:0];

    always_comb
    begin
        result.sample_out = y_zero_reg ? 16'sd0 : $signed(interp);
        result.underrun   = y_under_reg;
        result.position   = y_pos_reg;
        if (y_diff_reg[POS_W])
        begin
            result.headroom = DEPTH_W[10:0];
        end
        else if (y_diff_reg[POS_W-1:0] >= DEPTH_W)
        begin
            result.headroom = '0;
        end
        else
        begin
            result.headroom = room[10:0];
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (y_valid_reg)
        begin
            queue_reg[q_wr_ptr_reg] <= result;
        end
    end

    // Queue pointers, queue count and count of transactions not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (y_valid_reg)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QAW'(1);
            end
            if (out_fire)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QAW'(1);
            end
            q_count_reg  <= q_count_reg + (QAW+1)'(y_valid_reg) - (QAW+1)'(out_fire);
            inflight_reg <= inflight_reg + (QAW+1)'(in_fire) - (QAW+1)'(out_fire);
        end
    end

    assign out_valid = (q_count_reg != '0);
    assign out_data  = queue_reg[q_rd_ptr_reg];

    // The load phase is always followed by the update phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOAD) |=> (phase_reg == PH_UPDATE))
        else $error("load phase not followed by update phase");

    // A finished result never arrives at a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        y_valid_reg |-> (q_count_reg < (QAW+1)'(QDEPTH)))
        else $error("result queue overflow");

    // Queued results never outnumber undelivered transactions, which never exceed the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_count_reg <= inflight_reg) && (inflight_reg <= (QAW+1)'(QDEPTH)))
        else $error("occupancy accounting broken");

    // No ring write and read are issued for the same transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("ring write and read in the same cycle");

endmodule

/* hdl/rrl_ring_mem.sv */
// Sample ring storage: one write port and two registered read ports.
// Used by ring_resampler_linear_interp; depends on nothing else.
module rrl_ring_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [15:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr_a,
    input  logic [AW-1:0]      rd_addr_b,
    output logic signed [15:0] rd_data_a,
    output logic signed [15:0] rd_data_b
);

    logic signed [15:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
